[rtl/quadratic_edge_load_vector_unit_assert.svh]
// assertion macros for the edge load vector unit
`ifndef QUADRATIC_EDGE_LOAD_VECTOR_UNIT_ASSERT_SVH
`define QUADRATIC_EDGE_LOAD_VECTOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define QEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define QEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/qelv_pkg.sv]
// shared types, constants and gauss tables for the edge load vector unit
`timescale 1ns / 1ps
package qelv_pkg;
  localparam int MaxPoints = 4;
  localparam int PtW = 2;
  localparam int LimW = 48;

  typedef struct packed {
    logic signed [31:0] x1, x2, x3, y1, y2, y3, p, t;
  } edge_t;

  typedef struct packed {
    logic signed [LimW-1:0] f1x, f1y, f2x, f2y, f3x, f3y;
  } load_t;

  // per-point control that rides along the point pipeline
  typedef struct packed {
    logic       first;
    logic       last;
  } pt_ctl_t;

  function automatic logic signed [31:0] gauss_pt(input logic [2:0] ord,
                                                  input logic [PtW-1:0] i);
    logic signed [31:0] r;
    r = 32'sd0;
    case (ord)
      3'd2: r = (i == 2'd0) ? -32'sd619925131 : 32'sd619925131;
      3'd3: case (i)
        2'd0: r = -32'sd831716840;
        2'd2: r = 32'sd831716840;
        default: r = 32'sd0;
      endcase
      3'd4: case (i)
        2'd0: r = -32'sd924638074;
        2'd1: r = -32'sd365051866;
        2'd2: r = 32'sd365051866;
        default: r = 32'sd924638074;
      endcase
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] gauss_wt(input logic [2:0] ord,
                                                  input logic [PtW-1:0] i);
    logic signed [32:0] r;
    r = 33'sd0;
    case (ord)
      3'd2: r = 33'sd1073741824;
      3'd3: r = (i == 2'd1) ? 33'sd954437177 : 33'sd596523236;
      3'd4: r = (i == 2'd1 || i == 2'd2) ? 33'sd700235528 : 33'sd373506296;
      default: r = 33'sd2147483648;
    endcase
    return r;
  endfunction
endpackage

[rtl/qelv_point_gen.sv]
// walks the gauss points of one edge beat, one point per cycle while adv is high
`timescale 1ns / 1ps
module qelv_point_gen import qelv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        order,
  input  logic              in_valid,
  output logic              in_ready,
  input  edge_t             in_edge,
  input  logic              adv,
  output logic              pt_valid,
  output pt_ctl_t           pt_ctl,
  output logic signed [31:0] pt_s,
  output logic signed [32:0] pt_w,
  output edge_t             pt_edge
);
  logic [2:0] ord_eff;
  logic       busy_r, busy_nxt;
  logic [PtW-1:0] idx_r, idx_nxt;
  edge_t      edge_r;
  logic [2:0] ord_r;
  logic       is_last;

  assign ord_eff = (order == 3'd0) ? 3'd1 : (order > 3'(MaxPoints)) ? 3'(MaxPoints) : order;
  assign is_last = ({1'b0, idx_r} == ord_r - 3'd1);
  assign in_ready = !busy_r || (adv && is_last);
  assign pt_valid = busy_r;
  assign pt_ctl = '{first: (idx_r == '0), last: is_last};
  assign pt_s = gauss_pt(ord_r, idx_r);
  assign pt_w = gauss_wt(ord_r, idx_r);
  assign pt_edge = edge_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt = idx_r;
    if (busy_r && adv) begin
      idx_nxt = idx_r + 1'b1;
      if (is_last) busy_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
    end
    if (in_valid && in_ready) begin
      edge_r <= in_edge;
      ord_r <= ord_eff;
    end
  end
endmodule

[rtl/qelv_point_pipe.sv]
// multi-stage pipeline from one gauss point to its six load contributions
`timescale 1ns / 1ps
`include "quadratic_edge_load_vector_unit_assert.svh"
module qelv_point_pipe import qelv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               pt_valid,
  input  pt_ctl_t            pt_ctl,
  input  logic signed [31:0] pt_s,
  input  logic signed [32:0] pt_w,
  input  edge_t              pt_edge,
  output logic               c_valid,
  output pt_ctl_t            c_ctl,
  output logic signed [63:0] c_val [6]
);
  // stage 1: s*s and derivative products
  logic v1_r; pt_ctl_t k1_r;
  logic signed [63:0] ss1_r;
  logic signed [31:0] s1_r; logic signed [32:0] w1_r;
  logic signed [65:0] px1_r [3], py1_r [3];
  logic signed [31:0] p1_r, t1_r;
  logic signed [32:0] dn [3];
  // stage 2: shape values, tangent (tangent fits 34 bits)
  logic v2_r; pt_ctl_t k2_r;
  logic signed [32:0] w2_r;
  logic signed [33:0] n2_r [3];
  logic signed [33:0] dx2_r, dy2_r;
  logic signed [31:0] p2_r, t2_r;
  // stage 3: tangent times loads and w*N
  logic v3_r; pt_ctl_t k3_r;
  logic signed [127:0] a3_r [4];
  logic signed [66:0] wn3_r [3];
  // stage 4: rounded g (50 bits) and wN (33 bits)
  logic v4_r; pt_ctl_t k4_r;
  logic signed [49:0] gx4_r, gy4_r;
  logic signed [32:0] wn4_r [3];
  // stage 5: partial products on the low and high halves of g
  logic v5_r; pt_ctl_t k5_r;
  logic signed [58:0] pl5_r [6];
  logic signed [57:0] ph5_r [6];
  // stage 6: recombined products
  logic v6_r; pt_ctl_t k6_r;
  logic signed [127:0] pr6_r [6];

  function automatic logic signed [63:0] rnd(input logic signed [127:0] v, input int sh);
    logic signed [127:0] a, q;
    a = v + (128'sd1 <<< (sh - 1));
    q = a >>> sh;
    if (q > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (q < -128'sh8000000000000000) return 64'sh8000000000000000;
    return q[63:0];
  endfunction

  assign dn[0] = 33'(pt_s) + 33'sd536870912;
  assign dn[1] = 33'(pt_s) - 33'sd536870912;
  assign dn[2] = -(33'(pt_s) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pt_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r;
    end
    if (adv) begin
      k1_r <= pt_ctl; s1_r <= pt_s; w1_r <= pt_w;
      ss1_r <= 64'(pt_s) * 64'(pt_s);
      px1_r[0] <= 66'(dn[0]) * 66'(pt_edge.x1);
      px1_r[1] <= 66'(dn[1]) * 66'(pt_edge.x2);
      px1_r[2] <= 66'(dn[2]) * 66'(pt_edge.x3);
      py1_r[0] <= 66'(dn[0]) * 66'(pt_edge.y1);
      py1_r[1] <= 66'(dn[1]) * 66'(pt_edge.y2);
      py1_r[2] <= 66'(dn[2]) * 66'(pt_edge.y3);
      p1_r <= pt_edge.p; t1_r <= pt_edge.t;

      k2_r <= k1_r; w2_r <= w1_r; p2_r <= p1_r; t2_r <= t1_r;
      n2_r[0] <= 34'(rnd(128'(rnd(128'(ss1_r), 30)) + 128'(s1_r), 1));
      n2_r[1] <= 34'(rnd(128'(rnd(128'(ss1_r), 30)) - 128'(s1_r), 1));
      n2_r[2] <= 34'sd1073741824 - 34'(rnd(128'(ss1_r), 30));
      dx2_r <= 34'(rnd(128'(px1_r[0]) + 128'(px1_r[1]) + 128'(px1_r[2]), 30));
      dy2_r <= 34'(rnd(128'(py1_r[0]) + 128'(py1_r[1]) + 128'(py1_r[2]), 30));

      k3_r <= k2_r;
      a3_r[0] <= 128'(dy2_r) * 128'(p2_r);
      a3_r[1] <= 128'(dx2_r) * 128'(t2_r);
      a3_r[2] <= 128'(dx2_r) * 128'(p2_r);
      a3_r[3] <= 128'(dy2_r) * 128'(t2_r);
      for (int k = 0; k < 3; k++) wn3_r[k] <= 67'(w2_r) * 67'(n2_r[k]);

      k4_r <= k3_r;
      gx4_r <= 50'(rnd(a3_r[0] - a3_r[1], 16));
      gy4_r <= 50'(rnd(-(a3_r[2] + a3_r[3]), 16));
      for (int k = 0; k < 3; k++) wn4_r[k] <= 33'(rnd(128'(wn3_r[k]), 30));

      // g split into an unsigned low 25 bits and a signed high part
      k5_r <= k4_r;
      for (int k = 0; k < 3; k++) begin
        pl5_r[2*k]   <= 59'(wn4_r[k]) * 59'($signed({1'b0, gx4_r[24:0]}));
        pl5_r[2*k+1] <= 59'(wn4_r[k]) * 59'($signed({1'b0, gy4_r[24:0]}));
        ph5_r[2*k]   <= 58'(wn4_r[k]) * 58'($signed(gx4_r[49:25]));
        ph5_r[2*k+1] <= 58'(wn4_r[k]) * 58'($signed(gy4_r[49:25]));
      end

      k6_r <= k5_r;
      for (int k = 0; k < 6; k++) pr6_r[k] <= (128'(ph5_r[k]) <<< 25) + 128'(pl5_r[k]);
    end
  end

  assign c_valid = v6_r;
  assign c_ctl = k6_r;
  always_comb for (int k = 0; k < 6; k++) c_val[k] = rnd(pr6_r[k], 30);

  `QEL_ASSERT_NXT(a_v1, adv && pt_valid, v1_r, "point lost entering pipe")
  `QEL_ASSERT_NXT(a_hold, !adv, $stable(v6_r), "pipe moved while stalled")
  `QEL_ASSERT_NXT(a_v5, adv && v4_r, v5_r, "point lost at late stage")
endmodule

[rtl/qelv_accum.sv]
// sums point contributions and holds the saturated result beat
`timescale 1ns / 1ps
`include "quadratic_edge_load_vector_unit_assert.svh"
module qelv_accum import qelv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               c_valid,
  input  pt_ctl_t            c_ctl,
  input  logic signed [63:0] c_val [6],
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output load_t              out_load
);
  logic signed [63:0] acc_r [6], sum [6];
  logic signed [LimW-1:0] sat [6];
  logic ovalid_r;
  localparam logic signed [63:0] Lim = (64'sd1 <<< (LimW - 1)) - 64'sd1;

  assign adv = !(ovalid_r && !out_ready) || !(c_valid && c_ctl.last);
  assign out_valid = ovalid_r;

  always_comb for (int k = 0; k < 6; k++) begin
    sum[k] = (c_ctl.first ? 64'sd0 : acc_r[k]) + c_val[k];
    sat[k] = (sum[k] > Lim) ? Lim[LimW-1:0] :
             (sum[k] < -Lim - 64'sd1) ? LimW'(-Lim - 64'sd1) : sum[k][LimW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (c_valid && c_ctl.last && adv) ovalid_r <= 1'b1;
    else if (out_ready) ovalid_r <= 1'b0;
    if (c_valid && adv) for (int k = 0; k < 6; k++) acc_r[k] <= sum[k];
    if (c_valid && c_ctl.last && adv)
      out_load <= '{f1x: sat[0], f1y: sat[1], f2x: sat[2], f2y: sat[3],
                    f3x: sat[4], f3y: sat[5]};
  end

  `QEL_ASSERT_NXT(a_out, c_valid && c_ctl.last && adv, ovalid_r, "result beat lost")
  `QEL_ASSERT_NXT(a_keep, ovalid_r && !out_ready, ovalid_r && $stable(out_load),
                  "result dropped while stalled")
  `QEL_ASSERT_IMP(a_adv, ovalid_r && !out_ready && c_valid && c_ctl.last, !adv,
                  "overwrite of pending result")
endmodule

[rtl/quadratic_edge_load_vector_unit.sv]
// top level of the quadratic edge load vector unit
`timescale 1ns / 1ps
// consistent nodal loads of one three-node quadratic edge
// in channel: one beat per edge, tdata = node1_x, node2_x, node3_x,
//   node1_y, node2_y, node3_y, pressure, traction (32 bits each, Q16.16)
// out channel: one beat per edge, tdata = node1_force_x .. node3_force_y,
//   48 bits each, Q32.16, saturated
// cfg: cfg_we with cfg_wdata sets the gauss order (1..4, 0 acts as 1,
//   above 4 acts as 4); write only while idle
// throughput: one gauss point per cycle while the pipe advances; an edge
//   yields order points (1..4) and the next edge enters right behind it
// path: the point generator, the six register stages of the point pipeline
//   and the result register lie between the in beat and out_tvalid
// reset: rst_n low clears all valid bits, order returns to 3
// stall: when the out beat waits, the point pipe freezes only if its
//   final point would overwrite it; nothing is dropped or repeated
module quadratic_edge_load_vector_unit import qelv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // node1_x, node2_x, node3_x, node1_y, node2_y, node3_y, pressure, traction
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // node1_force_x, node1_force_y, node2_force_x, node2_force_y,
  // node3_force_x, node3_force_y
  output logic [287:0] out_tdata
);
  logic [2:0] order_r;
  edge_t in_edge;
  logic adv, pt_valid, c_valid, gen_ready;
  pt_ctl_t pt_ctl, c_ctl;
  logic signed [31:0] pt_s;
  logic signed [32:0] pt_w;
  edge_t pt_edge;
  logic signed [63:0] c_val [6];
  load_t out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 3'd3;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  assign in_edge = '{x1: in_tdata[31:0], x2: in_tdata[63:32], x3: in_tdata[95:64],
                     y1: in_tdata[127:96], y2: in_tdata[159:128], y3: in_tdata[191:160],
                     p: in_tdata[223:192], t: in_tdata[255:224]};
  assign in_tready = gen_ready;

  qelv_point_gen u_gen (
    .clk, .rst_n, .order(order_r), .in_valid(in_tvalid), .in_ready(gen_ready),
    .in_edge, .adv, .pt_valid, .pt_ctl, .pt_s, .pt_w, .pt_edge
  );

  qelv_point_pipe u_pipe (
    .clk, .rst_n, .adv, .pt_valid, .pt_ctl, .pt_s, .pt_w, .pt_edge,
    .c_valid, .c_ctl, .c_val
  );

  qelv_accum u_acc (
    .clk, .rst_n, .c_valid, .c_ctl, .c_val, .adv,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_load
  );

  assign out_tdata = {out_load.f3y, out_load.f3x, out_load.f2y, out_load.f2x,
                      out_load.f1y, out_load.f1x};
endmodule
